[hdl/screen_transition_reveal_mask_assert.svh]
// Assertion macros for the reveal mask port checker
`ifndef SCREEN_TRANSITION_REVEAL_MASK_ASSERT_SVH
`define SCREEN_TRANSITION_REVEAL_MASK_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define STRM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define STRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define STRM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/strm_pkg.sv]
// Shared constants, types and helpers for the screen transition reveal mask
`timescale 1ns / 1ps

package strm_pkg;

   // Screen geometry
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 160;
   localparam int CENTER_X      = SCREEN_WIDTH / 2;
   localparam int CENTER_Y      = SCREEN_HEIGHT / 2;

   // Pipeline depth, input register through output register
   localparam int PIPE_STAGES = 5;

   // Step counts per pattern
   localparam int WIPE_STEPS     = SCREEN_WIDTH;
   localparam int BLINDS_STEPS   = SCREEN_WIDTH / 8;
   localparam int DISSOLVE_STEPS = 80;
   localparam int CIRCLE_STEPS   = 120;
   localparam int DIAGONAL_STEPS = SCREEN_WIDTH + SCREEN_HEIGHT;
   localparam int CHECKER_STEPS  = 32;

   // Dissolve: 32x40 grid of 4x4 blocks, 17 picks per step, multiplier 997
   localparam int DISSOLVE_CELLS   = (SCREEN_WIDTH / 4) * (SCREEN_HEIGHT / 4);
   localparam int DISSOLVE_PER     = DISSOLVE_CELLS / DISSOLVE_STEPS + 1;
   // 997 * 493 = 1 mod 1280
   localparam int DISSOLVE_INVERSE = 493;

   // Checker: 16x20 grid of 8x8 tiles, 11 picks per step, multiplier 179
   localparam int CHECKER_CELLS   = (SCREEN_WIDTH / 8) * (SCREEN_HEIGHT / 8);
   localparam int CHECKER_PER     = CHECKER_CELLS / CHECKER_STEPS + 1;
   // 179 * 59 = 1 mod 320
   localparam int CHECKER_INVERSE = 59;

   // Circle: 14400 * d2 against 10496 * s^2
   localparam int CIRCLE_LHS_SCALE = CIRCLE_STEPS * CIRCLE_STEPS;
   localparam int CIRCLE_RHS_SCALE = CENTER_X * CENTER_X + CENTER_Y * CENTER_Y;

   // floor(q / 5) = (q * 3277) >> 14, exact for q below 4096
   localparam int DIV5_RECIP = 3277;
   localparam int DIV5_SHIFT = 14;

   // Pattern codes; 6 and 7 select an empty pattern
   typedef enum logic [2:0] {
      COLUMN_WIPE = 3'd0,
      BLINDS      = 3'd1,
      DISSOLVE    = 3'd2,
      CIRCLE      = 3'd3,
      DIAGONAL    = 3'd4,
      CHECKER     = 3'd5
   } kind_type;

   // Fields that ride along the whole pipeline
   typedef struct packed {
      kind_type    kind;
      logic [14:0] addr;
      logic        beyond;
      logic        last_step;
      logic        live;
      logic        simple_hit;
      logic [10:0] dis_lo;
      logic [8:0]  chk_lo;
   } tag_type;

   // First stage contents
   typedef struct packed {
      tag_type     tag;
      logic [6:0]  dx;
      logic [7:0]  dy;
      logic [6:0]  circ_step;
      logic [10:0] dis_cell;
      logic [8:0]  chk_cell;
   } front_type;

   // Third stage contents
   typedef struct packed {
      tag_type     tag;
      logic [28:0] lhs;
      logic [27:0] rhs_hi;
      logic [27:0] rhs_lo;
      logic [11:0] dis_q;
      logic [9:0]  dis_quot;
      logic [7:0]  dis_low;
      logic [8:0]  chk_q;
      logic [6:0]  chk_quot;
      logic [5:0]  chk_low;
   } arith_type;

   // Result register contents
   typedef struct packed {
      logic        copy_now;
      logic [14:0] source_address;
      logic        final_step;
      logic        beyond_end;
   } result_type;

   // Number of steps of a pattern
   function automatic logic [8:0] step_count(kind_type kind);
      logic [8:0] count;
      unique case (kind)
         COLUMN_WIPE: count = 9'(WIPE_STEPS);
         BLINDS:      count = 9'(BLINDS_STEPS);
         DISSOLVE:    count = 9'(DISSOLVE_STEPS);
         CIRCLE:      count = 9'(CIRCLE_STEPS);
         DIAGONAL:    count = 9'(DIAGONAL_STEPS);
         CHECKER:     count = 9'(CHECKER_STEPS);
         default:     count = 9'd0;
      endcase
      return count;
   endfunction

endpackage

[hdl/strm_front.sv]
// Stage 1: step range checks, simple pattern matches, geometry for the arithmetic stages
`timescale 1ns / 1ps

module strm_front
   import strm_pkg::*;
(
   input  logic       clock,
   input  logic       load,
   input  kind_type   kind,
   input  logic [8:0] step,
   input  logic [6:0] col,
   input  logic [7:0] row,
   output front_type  front
);

   front_type   front_ff;
   front_type   front_in;
   logic [8:0]  count;
   logic [8:0]  diag_sum;
   logic [13:0] dis_lo_full;
   logic [12:0] chk_lo_full;

   // Step count, diagonal sum and pick window starts
   always_comb begin
      count = step_count(kind);
      diag_sum = {2'b00, col} + {1'b0, row};
      dis_lo_full = {5'b0, step} * 14'(DISSOLVE_PER);
      chk_lo_full = {4'b0, step} * 13'(CHECKER_PER);
   end

   always_comb begin
      front_in.tag.kind = kind;
      front_in.tag.addr = {row, col};
      front_in.tag.beyond = step >= count;
      front_in.tag.last_step = (count != 9'd0) && (step == count - 9'd1);
      front_in.tag.live = (step < count) && (row < 8'(SCREEN_HEIGHT));
      // Truncated window starts are only used while the step is in range
      front_in.tag.dis_lo = dis_lo_full[10:0];
      front_in.tag.chk_lo = chk_lo_full[8:0];

      // Patterns that need only a compare
      case (kind)
         COLUMN_WIPE: front_in.tag.simple_hit = ({2'b00, col} == step);
         BLINDS:      front_in.tag.simple_hit = ({5'b0, col[3:0]} == step);
         DIAGONAL:    front_in.tag.simple_hit = ({1'b0, diag_sum[8:1]} == step);
         default:     front_in.tag.simple_hit = 1'b0;
      endcase

      // Distance to the circle center
      front_in.dx = (col >= 7'(CENTER_X)) ? col - 7'(CENTER_X) : 7'(CENTER_X) - col;
      front_in.dy = (row >= 8'(CENTER_Y)) ? row - 8'(CENTER_Y) : 8'(CENTER_Y) - row;
      front_in.circ_step = step[6:0];

      // Block and tile indexes
      front_in.dis_cell = {row[7:2], col[6:2]};
      front_in.chk_cell = {row[7:3], col[6:3]};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

[hdl/strm_arith.sv]
// Stages 2 and 3: squares and inverse products, then scaled circle terms and mod-5 quotients
`timescale 1ns / 1ps

module strm_arith
   import strm_pkg::*;
(
   input  logic      clock,
   input  logic      load_mul,
   input  logic      load_scale,
   input  front_type front,
   output arith_type arith
);

   // Stage 2 registers
   tag_type     tag2_ff;
   logic [12:0] dx2_ff;
   logic [14:0] dy2_ff;
   logic [14:0] sq_hi_ff;
   logic [13:0] sq_lo_ff;
   logic [19:0] dis_prod_ff;
   logic [14:0] chk_prod_ff;

   logic [12:0] dx2_in;
   logic [14:0] dy2_in;
   logic [14:0] sq_hi_in;
   logic [13:0] sq_lo_in;
   logic [19:0] dis_prod_in;
   logic [14:0] chk_prod_in;

   logic [7:0]  step_plus;
   logic [13:0] dx2_full;
   logic [15:0] dy2_full;
   logic [15:0] sq_hi_full;
   logic [13:0] sq_lo_full;

   // Stage 3 registers
   arith_type   arith_ff;
   arith_type   arith_in;

   logic [15:0] dist2;
   logic [29:0] lhs_full;
   logic [28:0] rhs_hi_full;
   logic [27:0] rhs_lo_full;
   logic [23:0] dis_quot_full;
   logic [20:0] chk_quot_full;

   // Squares for the ring test; mapping of cells back to their pick number
   always_comb begin
      step_plus = {1'b0, front.circ_step} + 8'd1;
      dx2_full = {7'b0, front.dx} * {7'b0, front.dx};
      dy2_full = {8'b0, front.dy} * {8'b0, front.dy};
      sq_hi_full = {8'b0, step_plus} * {8'b0, step_plus};
      sq_lo_full = {7'b0, front.circ_step} * {7'b0, front.circ_step};
      dx2_in = dx2_full[12:0];
      dy2_in = dy2_full[14:0];
      sq_hi_in = sq_hi_full[14:0];
      sq_lo_in = sq_lo_full;
      dis_prod_in = {9'b0, front.dis_cell} * 20'(DISSOLVE_INVERSE);
      chk_prod_in = {6'b0, front.chk_cell} * 15'(CHECKER_INVERSE);
   end

   always_ff @(posedge clock) begin
      if (load_mul) begin
         tag2_ff     <= front.tag;
         dx2_ff      <= dx2_in;
         dy2_ff      <= dy2_in;
         sq_hi_ff    <= sq_hi_in;
         sq_lo_ff    <= sq_lo_in;
         dis_prod_ff <= dis_prod_in;
         chk_prod_ff <= chk_prod_in;
      end
   end

   // Scaled ring bounds and quotients for the mod 1280 / mod 320 reduction
   always_comb begin
      dist2 = {3'b0, dx2_ff} + {1'b0, dy2_ff};
      lhs_full = {14'b0, dist2} * 30'(CIRCLE_LHS_SCALE);
      rhs_hi_full = {14'b0, sq_hi_ff} * 29'(CIRCLE_RHS_SCALE);
      rhs_lo_full = {14'b0, sq_lo_ff} * 28'(CIRCLE_RHS_SCALE);
      dis_quot_full = {12'b0, dis_prod_ff[19:8]} * 24'(DIV5_RECIP);
      chk_quot_full = {12'b0, chk_prod_ff[14:6]} * 21'(DIV5_RECIP);

      arith_in.tag = tag2_ff;
      arith_in.lhs = lhs_full[28:0];
      arith_in.rhs_hi = rhs_hi_full[27:0];
      arith_in.rhs_lo = rhs_lo_full;
      arith_in.dis_q = dis_prod_ff[19:8];
      arith_in.dis_quot = dis_quot_full[DIV5_SHIFT +: 10];
      arith_in.dis_low = dis_prod_ff[7:0];
      arith_in.chk_q = chk_prod_ff[14:6];
      arith_in.chk_quot = chk_quot_full[DIV5_SHIFT +: 7];
      arith_in.chk_low = chk_prod_ff[5:0];
   end

   always_ff @(posedge clock) begin
      if (load_scale) begin
         arith_ff <= arith_in;
      end
   end

   assign arith = arith_ff;

endmodule

[hdl/strm_match.sv]
// Stages 4 and 5: ring compare and cell residues, then pick windows and the result register
`timescale 1ns / 1ps

module strm_match
   import strm_pkg::*;
(
   input  logic       clock,
   input  logic       load_resid,
   input  logic       load_out,
   input  arith_type  arith,
   output result_type result
);

   // Stage 4 registers
   tag_type     tag4_ff;
   logic        circle_hit_ff;
   logic [10:0] dis_res_ff;
   logic [8:0]  chk_res_ff;

   logic        circle_hit_in;
   logic [10:0] dis_res_in;
   logic [8:0]  chk_res_in;
   logic [11:0] dis_rem;
   logic [8:0]  chk_rem;

   // Stage 5 registers
   result_type  result_ff;
   result_type  result_in;

   logic [11:0] dis_lo;
   logic [11:0] dis_hi;
   logic [11:0] dis_a;
   logic [11:0] dis_b;
   logic [9:0]  chk_lo;
   logic [9:0]  chk_hi;
   logic [9:0]  chk_a;
   logic [9:0]  chk_b;
   logic        dis_hit;
   logic        chk_hit;
   logic        pattern_hit;

   // Ring test and remainders: v mod 1280 = (q mod 5) * 256 + low byte
   always_comb begin
      circle_hit_in = (arith.lhs <= {1'b0, arith.rhs_hi}) &&
                      (arith.lhs > {1'b0, arith.rhs_lo});
      dis_rem = arith.dis_q - ({arith.dis_quot, 2'b00} + {2'b00, arith.dis_quot});
      chk_rem = arith.chk_q - ({arith.chk_quot, 2'b00} + {2'b00, arith.chk_quot});
      dis_res_in = {dis_rem[2:0], arith.dis_low};
      chk_res_in = {chk_rem[2:0], arith.chk_low};
   end

   always_ff @(posedge clock) begin
      if (load_resid) begin
         tag4_ff       <= arith.tag;
         circle_hit_ff <= circle_hit_in;
         dis_res_ff    <= dis_res_in;
         chk_res_ff    <= chk_res_in;
      end
   end

   // Pick number is the residue or the residue plus one full wrap;
   // it must fall in the step's window of picks
   always_comb begin
      dis_lo = {1'b0, tag4_ff.dis_lo};
      dis_hi = dis_lo + 12'(DISSOLVE_PER - 1);
      dis_a = {1'b0, dis_res_ff};
      dis_b = dis_a + 12'(DISSOLVE_CELLS);
      dis_hit = ((dis_a >= dis_lo) && (dis_a <= dis_hi)) ||
                ((dis_b >= dis_lo) && (dis_b <= dis_hi));

      chk_lo = {1'b0, tag4_ff.chk_lo};
      chk_hi = chk_lo + 10'(CHECKER_PER - 1);
      chk_a = {1'b0, chk_res_ff};
      chk_b = chk_a + 10'(CHECKER_CELLS);
      chk_hit = ((chk_a >= chk_lo) && (chk_a <= chk_hi)) ||
                ((chk_b >= chk_lo) && (chk_b <= chk_hi));

      case (tag4_ff.kind) inside
         COLUMN_WIPE, BLINDS, DIAGONAL: pattern_hit = tag4_ff.simple_hit;
         DISSOLVE:                      pattern_hit = dis_hit;
         CIRCLE:                        pattern_hit = circle_hit_ff;
         CHECKER:                       pattern_hit = chk_hit;
         default:                       pattern_hit = 1'b0;
      endcase

      result_in.copy_now = tag4_ff.live && pattern_hit;
      result_in.source_address = tag4_ff.addr;
      result_in.final_step = tag4_ff.last_step;
      result_in.beyond_end = tag4_ff.beyond;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[hdl/screen_transition_reveal_mask.sv]
// Top level of the screen transition reveal mask pipeline
//
//   channel  direction  handshake                   payload
//   req      in         req_valid / req_stall       step_number, pixel_column, pixel_row
//   rsp      out        rsp_valid / rsp_stall       copy_now, source_address, final_step,
//                                                    beyond_end
//   csr      in         csr_write_enable            csr_write_data (pattern code)
//
// One request per cycle while req_stall is low; a result is offered once it reaches stage 5.
// The five register stages each advance when empty or when the next one moves, so
// bubbles close up under rsp_stall and req_stall rises only when every stage is full.
// Synchronous reset empties the pipeline and selects the column wipe pattern.
// The pattern code is sampled in stage 1 and travels with each request.
`timescale 1ns / 1ps

module screen_transition_reveal_mask
   import strm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [8:0]  req_step_number,
   input  logic [6:0]  req_pixel_column,
   input  logic [7:0]  req_pixel_row,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_copy_now,
   output logic [14:0] rsp_source_address,
   output logic        rsp_final_step,
   output logic        rsp_beyond_end,

   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data
);

   kind_type                kind_ff;
   kind_type                kind_in;
   logic [PIPE_STAGES-1:0]  valid_ff;
   logic [PIPE_STAGES-1:0]  valid_in;
   logic [PIPE_STAGES-1:0]  stage_en;
   front_type               front;
   arith_type               arith;
   result_type              result;

   // Pattern register
   always_comb begin
      kind_in = csr_write_enable ? kind_type'(csr_write_data) : kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= COLUMN_WIPE;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves
   always_comb begin
      stage_en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   // Valid bits follow the data
   always_comb begin
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   strm_front u_front (
      .clock (clock),
      .load  (stage_en[0]),
      .kind  (kind_ff),
      .step  (req_step_number),
      .col   (req_pixel_column),
      .row   (req_pixel_row),
      .front (front)
   );

   strm_arith u_arith (
      .clock      (clock),
      .load_mul   (stage_en[1]),
      .load_scale (stage_en[2]),
      .front      (front),
      .arith      (arith)
   );

   strm_match u_match (
      .clock      (clock),
      .load_resid (stage_en[3]),
      .load_out   (stage_en[4]),
      .arith      (arith),
      .result     (result)
   );

   // Ports
   assign req_stall          = !stage_en[0];
   assign rsp_valid          = valid_ff[PIPE_STAGES-1];
   assign rsp_copy_now       = result.copy_now;
   assign rsp_source_address = result.source_address;
   assign rsp_final_step     = result.final_step;
   assign rsp_beyond_end     = result.beyond_end;

endmodule

[hdl/strm_port_checker.sv]
// Port-level checks for the screen transition reveal mask, bound to the top level
`timescale 1ns / 1ps
`include "screen_transition_reveal_mask_assert.svh"

module strm_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_copy_now,
   input logic [14:0] rsp_source_address,
   input logic        rsp_final_step,
   input logic        rsp_beyond_end
);

   // A stalled result stays offered
   `STRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "rsp_valid dropped while stalled")

   // A stalled result keeps its payload
   `STRM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_copy_now) && $stable(rsp_source_address) &&
      $stable(rsp_final_step) && $stable(rsp_beyond_end),
      "rsp payload changed while stalled")

   // Nothing is copied once the step is out of range
   `STRM_ASSERT_IMPL(a_beyond_no_copy, clock, reset, rsp_valid && rsp_beyond_end,
      !rsp_copy_now, "copy flagged past the last step")

   // The last step is always inside the range
   `STRM_ASSERT_IMPL(a_final_in_range, clock, reset, rsp_valid && rsp_final_step,
      !rsp_beyond_end, "final step flagged beyond the end")

   // Reset leaves the pipeline empty
   `STRM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "result offered right after reset")

endmodule

bind screen_transition_reveal_mask strm_port_checker u_port_checker (.*);
